// ===== rtl/wsfd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// Used by the header parser, the result queue and the output stage.
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASKKEY = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  localparam logic [6:0] LEN_CODE_16    = 7'd126;
  localparam logic [6:0] LEN_CODE_64    = 7'd127;
  localparam logic [3:0] TEXT_OPCODE    = 4'd1;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;
  localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       empty_frame;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/wsfd_parser.sv =====
// Front end: walks the frame header byte by byte and classifies each byte.
// Depends on wsfd_pkg for the phase type, length codes and result type.
`timescale 1ns / 1ps
`default_nettype none

module wsfd_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [7:0]        in_byte,
  output logic                   emit,
  output wsfd_pkg::result_t      result
);

  wsfd_pkg::phase_t phase_r, phase_nxt;
  logic             frame_is_text_r, frame_is_text_nxt;
  logic             mask_present_r, mask_present_nxt;
  logic [3:0]       hdr_left_r, hdr_left_nxt;
  logic [63:0]      remaining_r, remaining_nxt;

  logic [6:0]  len7;
  logic        len_is_ext;
  logic [63:0] ext_shift;
  logic [3:0]  hdr_left_dec;
  logic        hdr_done;
  logic        rem_is_zero;
  logic        rem_is_one;

  assign len7         = in_byte[6:0];
  assign len_is_ext   = (len7 == wsfd_pkg::LEN_CODE_16) || (len7 == wsfd_pkg::LEN_CODE_64);
  assign ext_shift    = {remaining_r[55:0], in_byte};
  assign hdr_left_dec = hdr_left_r - 4'd1;
  assign hdr_done     = (hdr_left_dec == 4'd0);
  assign rem_is_zero  = (remaining_r == 64'd0);
  assign rem_is_one   = (remaining_r == 64'd1);

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      wsfd_pkg::PH_HDR1: begin
        if (len_is_ext) begin
          phase_nxt = wsfd_pkg::PH_EXTLEN;
        end else if (in_byte[7]) begin
          phase_nxt = wsfd_pkg::PH_MASKKEY;
        end else if (len7 == 7'd0) begin
          phase_nxt = wsfd_pkg::PH_HDR0;
        end else begin
          phase_nxt = wsfd_pkg::PH_PAYLOAD;
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        if (hdr_done) begin
          if (mask_present_r) begin
            phase_nxt = wsfd_pkg::PH_MASKKEY;
          end else if (ext_shift == 64'd0) begin
            phase_nxt = wsfd_pkg::PH_HDR0;
          end else begin
            phase_nxt = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_MASKKEY: begin
        if (hdr_done) begin
          phase_nxt = rem_is_zero ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_PAYLOAD;
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        if (rem_is_one) begin
          phase_nxt = wsfd_pkg::PH_HDR0;
        end
      end
      default: begin
        phase_nxt = wsfd_pkg::PH_HDR1;
      end
    endcase
  end

  always_comb begin
    frame_is_text_nxt = frame_is_text_r;
    mask_present_nxt  = mask_present_r;
    hdr_left_nxt      = hdr_left_r;
    remaining_nxt     = remaining_r;
    emit              = 1'b0;
    result            = '0;
    unique case (phase_r)
      wsfd_pkg::PH_HDR1: begin
        mask_present_nxt = in_byte[7];
        if (len_is_ext) begin
          remaining_nxt = 64'd0;
          hdr_left_nxt  = (len7 == wsfd_pkg::LEN_CODE_16) ? wsfd_pkg::EXT16_BYTES
                                                          : wsfd_pkg::EXT64_BYTES;
        end else begin
          remaining_nxt = {57'd0, len7};
          if (in_byte[7]) begin
            hdr_left_nxt = wsfd_pkg::MASK_KEY_BYTES;
          end else if (len7 == 7'd0) begin
            emit = frame_is_text_r;
          end
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        remaining_nxt = ext_shift;
        hdr_left_nxt  = hdr_left_dec;
        if (hdr_done) begin
          if (mask_present_r) begin
            hdr_left_nxt = wsfd_pkg::MASK_KEY_BYTES;
          end else if (ext_shift == 64'd0) begin
            emit = frame_is_text_r;
          end
        end
      end
      wsfd_pkg::PH_MASKKEY: begin
        hdr_left_nxt = hdr_left_dec;
        if (hdr_done && rem_is_zero) begin
          emit = frame_is_text_r;
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        remaining_nxt = remaining_r - 64'd1;
        emit          = frame_is_text_r;
      end
      default: begin
        frame_is_text_nxt = (in_byte[3:0] == wsfd_pkg::TEXT_OPCODE);
        mask_present_nxt  = 1'b0;
        hdr_left_nxt      = 4'd0;
        remaining_nxt     = 64'd0;
      end
    endcase
    if (phase_r == wsfd_pkg::PH_PAYLOAD) begin
      result.payload_byte  = in_byte;
      result.last_of_frame = rem_is_one;
      result.empty_frame   = 1'b0;
    end else begin
      result.payload_byte  = 8'd0;
      result.last_of_frame = 1'b1;
      result.empty_frame   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= wsfd_pkg::PH_HDR0;
      frame_is_text_r <= 1'b0;
      mask_present_r  <= 1'b0;
      hdr_left_r      <= 4'd0;
      remaining_r     <= 64'd0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      frame_is_text_r <= frame_is_text_nxt;
      mask_present_r  <= mask_present_nxt;
      hdr_left_r      <= hdr_left_nxt;
      remaining_r     <= remaining_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_text_payload_emits: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (phase_r == wsfd_pkg::PH_PAYLOAD) && frame_is_text_r |-> emit)
    else $error("text payload byte produced no result");

  a_empty_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
    accept && emit && result.empty_frame |=> phase_r == wsfd_pkg::PH_HDR0)
    else $error("empty frame result did not return to header start");

  a_last_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
    accept && emit && result.last_of_frame |=> phase_r == wsfd_pkg::PH_HDR0)
    else $error("final payload byte did not return to header start");
`endif

endmodule

`default_nettype wire

// ===== rtl/wsfd_fifo.sv =====
// Short result queue that decouples the header parser from the output stage.
// Depends on wsfd_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module wsfd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wsfd_pkg::result_t push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              head_valid,
  output wsfd_pkg::result_t head_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  wsfd_pkg::result_t entries_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_data  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> !pop)
    else $error("pop from an empty queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CW'(1))
    else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

// ===== rtl/wsfd_out.sv =====
// Back end: output register that presents queued results on the master side.
// Depends on wsfd_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module wsfd_out (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         head_valid,
  input  wsfd_pkg::result_t head_data,
  output logic              pop,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);

  logic              valid_r, valid_nxt;
  wsfd_pkg::result_t data_r;

  assign pop       = head_valid && (!valid_r || out_tready);
  assign valid_nxt = pop || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= head_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r.payload_byte;
  assign out_tlast  = data_r.last_of_frame;
  assign out_tuser  = data_r.empty_frame;

endmodule

`default_nettype wire

// ===== rtl/websocket_frame_deframer_unit.sv =====
// Top level of the WebSocket frame deframer: parser, result queue, output stage.
// Depends on wsfd_pkg, wsfd_parser, wsfd_fifo and wsfd_out.
//
// The block takes one received byte per cycle and splits the stream into frames,
// reading the opcode, mask bit and 7-bit, 16-bit or 64-bit length and skipping any
// mask key. Payload bytes of text frames come out unchanged with the final byte
// marked on out_tlast; an empty text frame gives one transaction with out_tuser
// set. The header parser never holds off a byte, so in_tready stays high at one
// byte per cycle until the result queue of FIFO_DEPTH entries fills because the
// master side is held off. Each result passes through the result queue and then
// the output register, so out_tvalid rises at the earliest at the clock edge after
// the one that accepts the byte.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_unit #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] payload_byte
  output logic            out_tlast,
  output logic            out_tuser   // [0] empty_frame
);

  logic              accept;
  logic              emit;
  wsfd_pkg::result_t result;
  logic              fifo_full;
  logic              pop;
  logic              head_valid;
  wsfd_pkg::result_t head_data;

  assign in_tready = !fifo_full;
  assign accept    = in_tvalid && in_tready;

  wsfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .emit    (emit),
    .result  (result)
  );

  wsfd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept && emit),
    .push_data  (result),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  wsfd_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
